// ----- rtl/core/isfi_pkg.sv -----
package isfi_pkg;

    // Item kinds
    localparam logic [1:0] FUNC_ACCEL = 2'd0;
    localparam logic [1:0] FUNC_GYRO  = 2'd1;
    localparam logic [1:0] FUNC_ANGLE = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ACCEL_SMOOTHING = 2'd0;
    localparam logic [1:0] REG_RATE_SMOOTHING  = 2'd1;
    localparam logic [1:0] REG_ANGLE_SMOOTHING = 2'd2;
    localparam logic [1:0] REG_TIME_STEP       = 2'd3;

    // Register reset values
    localparam logic [16:0] SMOOTHING_RESET = 17'd6554;
    localparam logic [20:0] TIME_STEP_RESET = 21'd16777;

    // Scale factors: accel = round(count * 2943 / 25), rate = count * 4000
    localparam logic [28:0] ACCEL_NUM = 29'd2943;
    localparam logic [28:0] RATE_MUL  = 29'd4000;
    localparam logic [26:0] ACCEL_HALF_DEN = 27'd12;
    localparam logic [27:0] ACCEL_DEN = 28'd25;
    // floor(2^32 / 25)
    localparam logic [28:0] RECIP_25 = 29'd171798691;

    // Q16.16 constants
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;
    localparam logic signed [31:0] DEG360 = 32'sd23592960;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RECIP,
        ST_FIX,
        ST_SMUL,
        ST_SFIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] scaled_x;
        logic signed [31:0] scaled_y;
        logic signed [31:0] scaled_z;
        logic signed [31:0] smooth_x;
        logic signed [31:0] smooth_y;
        logic signed [31:0] smooth_z;
    } result_t;

endpackage

// ----- rtl/core/imu_scale_filter_integrate_unit.sv -----
// IMU scaling, smoothing and gyro integration unit.
// Input channel (sample_valid / sample_stall / sample) takes one word per
// item: func selects accel sample, gyro sample or angle tick; raw_x/y/z are
// signed counts. Output channel (result_valid / result_stall / result) gives
// one word per item: kind, scaled (or wrapped angle) and smoothed x/y/z in
// Q16.16. An unused func code is taken and gives no word.
// Weights and time step are set through the APB port at 4*index.
// One shared 33x30 multiplier is stepped by a small sequencer over the three
// axes: first a scale pass for each axis (multiply, reciprocal and fix steps
// for accel; multiply and fix for gyro/tick), then a smoothing pass for each
// axis (multiply and fix steps). One item is in work at a time, and
// sample_stall is high for the whole pass, so a new item is taken only once
// the previous one has left the sequencer.
// The result sits in an output register, so a new item is taken while the
// previous word waits; the sequencer holds at its last step if the output
// register is still full and stalled.
// Reset clears all smoother state, the priming flags, the integrated angles
// and last rates, and loads the register defaults.
module imu_scale_filter_integrate_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  isfi_pkg::sample_t   sample,
    output logic                result_valid,
    input  logic                result_stall,
    output isfi_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import isfi_pkg::*;

    // Config registers
    logic [16:0] accel_w_reg, rate_w_reg, angle_w_reg;
    logic [20:0] time_step_reg;

    // Sequencer
    state_t      state_reg, state_next;
    logic [1:0]  ax_reg;
    sample_t     item_reg;

    // Datapath registers
    logic signed [62:0] prod_reg;
    logic [26:0]        mag_reg;
    logic               neg_reg;
    logic signed [31:0] xv_reg     [3];
    logic signed [31:0] sc_reg     [3];
    logic signed [31:0] accel_sm_reg [3];
    logic signed [31:0] rate_sm_reg  [3];
    logic signed [31:0] angle_sm_reg [3];
    logic signed [31:0] rate_last_reg [3];
    logic signed [31:0] angle_sum_reg [3];
    logic [2:0]         primed_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    // Controls
    logic take, last_ax, out_free, load_out;

    // Shared multiplier
    logic signed [32:0] mul_a;
    logic [28:0]        mul_b;
    logic signed [62:0] mul_p;

    // Combinational values
    logic signed [15:0] raw_cur;
    logic signed [31:0] s_cur;
    logic [16:0]        w_sel, w_clip;
    logic signed [27:0] p28;
    logic [27:0]        pmag;
    logic [26:0]        mag_next;
    logic [22:0]        q0;
    logic [27:0]        q0x25, rem;
    logic [22:0]        q;
    logic signed [31:0] accel_val;
    logic signed [62:0] step_rnd;
    logic signed [31:0] raw_sum, wrapped;
    logic signed [50:0] acc, acc_rnd;
    logic signed [31:0] sm_new;
    logic [2:0]         kind_hot;

    // APB
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ACCEL_SMOOTHING: prdata = {15'd0, accel_w_reg};
            REG_RATE_SMOOTHING:  prdata = {15'd0, rate_w_reg};
            REG_ANGLE_SMOOTHING: prdata = {15'd0, angle_w_reg};
            REG_TIME_STEP:       prdata = {11'd0, time_step_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_w_reg   <= SMOOTHING_RESET;
            rate_w_reg    <= SMOOTHING_RESET;
            angle_w_reg   <= SMOOTHING_RESET;
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_ACCEL_SMOOTHING: accel_w_reg   <= pwdata[16:0];
                REG_RATE_SMOOTHING:  rate_w_reg    <= pwdata[16:0];
                REG_ANGLE_SMOOTHING: angle_w_reg   <= pwdata[16:0];
                REG_TIME_STEP:       time_step_reg <= pwdata[20:0];
                default:             ;
            endcase
        end
    end

    // Handshake
    assign sample_stall = (state_reg != ST_IDLE);
    assign take         = sample_valid && !sample_stall;
    assign last_ax      = (ax_reg == 2'd2);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (sample.func == FUNC_ACCEL || sample.func == FUNC_GYRO
                             || sample.func == FUNC_ANGLE))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (item_reg.func == FUNC_ACCEL)
                    state_next = ST_RECIP;
                else
                    state_next = ST_FIX;
            end
            ST_RECIP: state_next = ST_FIX;
            ST_FIX:   state_next = last_ax ? ST_SMUL : ST_MUL;
            ST_SMUL:  state_next = ST_SFIX;
            ST_SFIX:  state_next = last_ax ? ST_DONE : ST_SMUL;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load_out = 1'b0;
        unique case (state_reg)
            ST_DONE: load_out = out_free;
            default: load_out = 1'b0;
        endcase
    end

    // Operand selects
    always_comb
    begin
        case (ax_reg)
            2'd0:    raw_cur = item_reg.raw_x;
            2'd1:    raw_cur = item_reg.raw_y;
            default: raw_cur = item_reg.raw_z;
        endcase
    end

    always_comb
    begin
        case (item_reg.func)
            FUNC_ACCEL:
            begin
                s_cur = accel_sm_reg[ax_reg];
                w_sel = accel_w_reg;
            end
            FUNC_GYRO:
            begin
                s_cur = rate_sm_reg[ax_reg];
                w_sel = rate_w_reg;
            end
            default:
            begin
                s_cur = angle_sm_reg[ax_reg];
                w_sel = angle_w_reg;
            end
        endcase
    end

    // Weight above one acts as one
    assign w_clip = w_sel[16] ? WEIGHT_ONE : w_sel;

    // Magnitude of count * 2943 plus half divisor
    assign p28      = prod_reg[27:0];
    assign pmag     = prod_reg[62] ? 28'(-p28) : 28'(p28);
    assign mag_next = pmag[26:0] + ACCEL_HALF_DEN;

    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 29'd0;
        case (state_reg)
            ST_MUL:
            begin
                if (item_reg.func == FUNC_ANGLE)
                begin
                    mul_a = 33'(rate_last_reg[ax_reg]);
                    mul_b = {8'd0, time_step_reg};
                end
                else
                begin
                    mul_a = 33'(raw_cur);
                    mul_b = (item_reg.func == FUNC_ACCEL) ? ACCEL_NUM : RATE_MUL;
                end
            end
            ST_RECIP:
            begin
                mul_a = $signed({6'd0, mag_next});
                mul_b = RECIP_25;
            end
            ST_SMUL:
            begin
                mul_a = 33'(xv_reg[ax_reg]) - 33'(s_cur);
                mul_b = {12'd0, w_clip};
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 29'd0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Accel: quotient estimate, one correction step, sign back
    assign q0        = prod_reg[54:32];
    assign q0x25     = {1'b0, q0, 4'd0} + {2'd0, q0, 3'd0} + {5'd0, q0};
    assign rem       = {1'b0, mag_reg} - q0x25;
    assign q         = (rem >= ACCEL_DEN) ? q0 + 23'd1 : q0;
    assign accel_val = neg_reg ? -$signed({9'd0, q}) : $signed({9'd0, q});

    // Angle: step rounded at 2^-24, added, wrapped once
    assign step_rnd = prod_reg + 63'sd8388608 - 63'(prod_reg[62]);
    assign raw_sum  = angle_sum_reg[ax_reg] + 32'(step_rnd >>> 24);
    always_comb
    begin
        if (raw_sum > DEG180)
            wrapped = raw_sum - DEG360;
        else if (raw_sum < -DEG180)
            wrapped = raw_sum + DEG360;
        else
            wrapped = raw_sum;
    end

    // Smoother: s*2^16 + w*(x - s), rounded at 2^-16
    assign acc     = $signed({s_cur, 16'd0}) + 51'(prod_reg);
    assign acc_rnd = acc + 51'sd32768 - 51'(acc[50]);
    assign sm_new  = primed_reg[item_reg.func] ? acc_rnd[47:16] : xv_reg[ax_reg];

    assign kind_hot = 3'b001 << item_reg.func;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ax_reg           <= 2'd0;
            primed_reg       <= 3'b000;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FIX) || (state_reg == ST_SFIX))
                ax_reg <= last_ax ? 2'd0 : ax_reg + 2'd1;
            if ((state_reg == ST_SFIX) && last_ax)
                primed_reg <= primed_reg | kind_hot;
            if (load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // State kept across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                accel_sm_reg[i]  <= 32'sd0;
                rate_sm_reg[i]   <= 32'sd0;
                angle_sm_reg[i]  <= 32'sd0;
                rate_last_reg[i] <= 32'sd0;
                angle_sum_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            if ((state_reg == ST_FIX) && (item_reg.func == FUNC_GYRO))
                rate_last_reg[ax_reg] <= prod_reg[31:0];
            if ((state_reg == ST_FIX) && (item_reg.func == FUNC_ANGLE))
                angle_sum_reg[ax_reg] <= wrapped;
            if (state_reg == ST_SFIX)
            begin
                case (item_reg.func)
                    FUNC_ACCEL: accel_sm_reg[ax_reg] <= sm_new;
                    FUNC_GYRO:  rate_sm_reg[ax_reg]  <= sm_new;
                    default:    angle_sm_reg[ax_reg] <= sm_new;
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= sample;
        if ((state_reg == ST_MUL) || (state_reg == ST_RECIP) || (state_reg == ST_SMUL))
            prod_reg <= mul_p;
        if (state_reg == ST_RECIP)
        begin
            mag_reg <= mag_next;
            neg_reg <= prod_reg[62];
        end
        if (state_reg == ST_FIX)
        begin
            case (item_reg.func)
                FUNC_ACCEL:
                begin
                    xv_reg[ax_reg] <= accel_val;
                    sc_reg[ax_reg] <= accel_val;
                end
                FUNC_GYRO:
                begin
                    xv_reg[ax_reg] <= prod_reg[31:0];
                    sc_reg[ax_reg] <= prod_reg[31:0];
                end
                default:
                begin
                    xv_reg[ax_reg] <= raw_sum;
                    sc_reg[ax_reg] <= wrapped;
                end
            endcase
        end
        if (load_out)
        begin
            result_reg.kind     <= item_reg.func;
            result_reg.scaled_x <= sc_reg[0];
            result_reg.scaled_y <= sc_reg[1];
            result_reg.scaled_z <= sc_reg[2];
            case (item_reg.func)
                FUNC_ACCEL:
                begin
                    result_reg.smooth_x <= accel_sm_reg[0];
                    result_reg.smooth_y <= accel_sm_reg[1];
                    result_reg.smooth_z <= accel_sm_reg[2];
                end
                FUNC_GYRO:
                begin
                    result_reg.smooth_x <= rate_sm_reg[0];
                    result_reg.smooth_y <= rate_sm_reg[1];
                    result_reg.smooth_z <= rate_sm_reg[2];
                end
                default:
                begin
                    result_reg.smooth_x <= angle_sm_reg[0];
                    result_reg.smooth_y <= angle_sm_reg[1];
                    result_reg.smooth_z <= angle_sm_reg[2];
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_imu_scale_filter_integrate_unit.sv -----
module tb_imu_scale_filter_integrate_unit;
    import isfi_pkg::*;

    // func code the block takes but answers with no word
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_CAP    = 40;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_t     sample = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    imu_scale_filter_integrate_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // stimulus and scoreboard bookkeeping
    sample_t pending_samples [$];
    result_t expected_words [$];
    int      items_queued = 0;
    int      items_taken = 0;
    int      quiet_cycles = 0;
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;

    // mirror of the block's registers
    logic [16:0] w_accel = SMOOTHING_RESET;
    logic [16:0] w_rate  = SMOOTHING_RESET;
    logic [16:0] w_angle = SMOOTHING_RESET;
    logic [20:0] dt_ticks = TIME_STEP_RESET;

    // mirror of the block's filter and integrator state
    logic signed [31:0] accel_avg [3] = '{0, 0, 0};
    logic signed [31:0] rate_avg  [3] = '{0, 0, 0};
    logic signed [31:0] rate_held [3] = '{0, 0, 0};
    logic signed [31:0] angle_int [3] = '{0, 0, 0};
    logic signed [31:0] angle_avg [3] = '{0, 0, 0};
    bit                 avg_loaded [3] = '{0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // nearest, ties away from zero
    function automatic longint round_shift(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint round_div(longint v, longint d);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + d / 2) / d;
        return (v < 0) ? -mag : mag;
    endfunction

    // one axis of the exponential smoother; an unloaded smoother takes x as is
    function automatic logic signed [31:0] smooth_axis(logic signed [31:0] prev,
                                                       logic signed [31:0] x,
                                                       logic [16:0] w, bit loaded);
        longint wa;
        longint acc;
        if (!loaded)
            return x;
        wa = (w > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(w);
        acc = wa * longint'(x) + (longint'(WEIGHT_ONE) - wa) * longint'(prev);
        return 32'(round_shift(acc, 16));
    endfunction

    // scale, smooth and integrate one accepted sample word
    task automatic predict_word(input sample_t s, output bit makes_word,
                                output result_t w);
        logic signed [15:0] raw [3];
        logic signed [31:0] scaled [3];
        logic signed [31:0] avg [3];
        logic signed [31:0] sum;
        longint             delta;
        int                 i;
        raw[0] = s.raw_x;
        raw[1] = s.raw_y;
        raw[2] = s.raw_z;
        makes_word = 1'b1;
        w = '0;
        case (s.func)
            FUNC_ACCEL:
            begin
                for (i = 0; i < 3; i++)
                begin
                    scaled[i] = 32'(round_div(longint'(raw[i]) * longint'(ACCEL_NUM),
                                              longint'(ACCEL_DEN)));
                    accel_avg[i] = smooth_axis(accel_avg[i], scaled[i], w_accel,
                                               avg_loaded[FUNC_ACCEL]);
                end
                avg_loaded[FUNC_ACCEL] = 1'b1;
                avg = accel_avg;
            end
            FUNC_GYRO:
            begin
                for (i = 0; i < 3; i++)
                begin
                    scaled[i] = 32'(longint'(raw[i]) * longint'(RATE_MUL));
                    rate_held[i] = scaled[i];
                    rate_avg[i] = smooth_axis(rate_avg[i], scaled[i], w_rate,
                                              avg_loaded[FUNC_GYRO]);
                end
                avg_loaded[FUNC_GYRO] = 1'b1;
                avg = rate_avg;
            end
            FUNC_ANGLE:
            begin
                for (i = 0; i < 3; i++)
                begin
                    delta = round_shift(longint'(rate_held[i]) * longint'(dt_ticks), 24);
                    sum = 32'(longint'(angle_int[i]) + delta);
                    // smoother sees the sum before wrapping
                    angle_avg[i] = smooth_axis(angle_avg[i], sum, w_angle,
                                               avg_loaded[FUNC_ANGLE]);
                    while (sum > DEG180)
                        sum -= DEG360;
                    while (sum < -DEG180)
                        sum += DEG360;
                    angle_int[i] = sum;
                    scaled[i] = sum;
                end
                avg_loaded[FUNC_ANGLE] = 1'b1;
                avg = angle_avg;
            end
            default:
            begin
                makes_word = 1'b0;
            end
        endcase
        if (makes_word)
        begin
            w.kind     = s.func;
            w.scaled_x = scaled[0];
            w.scaled_y = scaled[1];
            w.scaled_z = scaled[2];
            w.smooth_x = avg[0];
            w.smooth_y = avg[1];
            w.smooth_z = avg[2];
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // sample driver: holds a stalled word, otherwise offers the next one at random
    always @(posedge clk)
    begin
        if (!sample_valid || !sample_stall)
        begin
            if (rst_n && pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                sample <= pending_samples.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on accepted samples, check accepted words
    always @(posedge clk)
    begin : monitor
        result_t want;
        bit      makes_word;
        bit      moved;
        moved = 1'b0;
        if (rst_n && sample_valid && !sample_stall)
        begin
            moved = 1'b1;
            items_taken++;
            predict_word(sample, makes_word, want);
            if (makes_word)
                expected_words.push_back(want);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            moved = 1'b1;
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected word, expected none, actual kind %0d",
                             $time, result.kind);
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("kind", int'(want.kind), int'(result.kind));
                check_field("scaled_x", want.scaled_x, result.scaled_x);
                check_field("scaled_y", want.scaled_y, result.scaled_y);
                check_field("scaled_z", want.scaled_z, result.scaled_z);
                check_field("smooth_x", want.smooth_x, result.smooth_x);
                check_field("smooth_y", want.smooth_y, result.smooth_y);
                check_field("smooth_z", want.smooth_z, result.smooth_z);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // watchdog on a stuck handshake
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("imu_scale_filter_integrate_unit verification failed");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ACCEL_SMOOTHING: w_accel = value[16:0];
            REG_RATE_SMOOTHING:  w_rate = value[16:0];
            REG_ANGLE_SMOOTHING: w_angle = value[16:0];
            REG_TIME_STEP:       dt_ticks = value[20:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] wa, input logic [31:0] wr,
                            input logic [31:0] wg, input logic [31:0] dt);
        write_reg(REG_ACCEL_SMOOTHING, wa);
        write_reg(REG_RATE_SMOOTHING, wr);
        write_reg(REG_ANGLE_SMOOTHING, wg);
        write_reg(REG_TIME_STEP, dt);
    endtask

    task automatic queue_item(input logic [1:0] f, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z);
        sample_t s;
        s.func = f;
        s.raw_x = x;
        s.raw_y = y;
        s.raw_z = z;
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // counts biased toward full scale, zero and minus one
    function automatic logic signed [15:0] pick_raw();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int count);
        int          n;
        int          r;
        logic [1:0]  f;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                f = FUNC_ACCEL;
            else if (r < 65)
                f = FUNC_GYRO;
            else if (r < 95)
                f = FUNC_ANGLE;
            else
                f = FUNC_UNUSED;
            queue_item(f, pick_raw(), pick_raw(), pick_raw());
        end
    endtask

    // wait until every word is taken and answered, then let the pipe settle
    task automatic drain();
        while (items_taken != items_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full scale counts, priming, exact +-180 hold and wrap
        // (rate 12500 counts with this step rounds to exactly 90 degrees per tick)
        set_regs(32'd6554, 32'd6554, 32'd6554, 32'd1979121);
        queue_item(FUNC_ACCEL, 16'sd32767, -16'sd32768, 16'sd0);
        queue_item(FUNC_ACCEL, -16'sd1, 16'sd1, 16'sd32767);
        queue_item(FUNC_ACCEL, -16'sd32768, 16'sd32767, -16'sd1);
        queue_item(FUNC_ANGLE, 16'sd32767, -16'sd32768, 16'sd0);
        queue_item(FUNC_GYRO, 16'sd12500, -16'sd12500, 16'sd0);
        queue_item(FUNC_ANGLE, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_ANGLE, -16'sd1, -16'sd1, -16'sd1);
        queue_item(FUNC_ANGLE, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_GYRO, 16'sd32767, -16'sd32768, -16'sd1);
        queue_item(FUNC_ANGLE, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_UNUSED, 16'sd32767, -16'sd1, -16'sd32768);
        queue_item(FUNC_GYRO, -16'sd32768, 16'sd32767, 16'sd1);
        queue_item(FUNC_ANGLE, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_ACCEL, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_UNUSED, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_ANGLE, 16'sd32767, 16'sd32767, 16'sd32767);
        queue_item(FUNC_ACCEL, 16'sd16384, -16'sd16384, 16'sd12345);
        queue_item(FUNC_GYRO, 16'sd0, 16'sd0, 16'sd0);
        queue_item(FUNC_ANGLE, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_item(FUNC_GYRO, 16'sd1, -16'sd1, 16'sd0);
        queue_item(FUNC_ANGLE, 16'sd0, 16'sd0, 16'sd0);
        drain();

        // no smoothing, no idling
        set_regs(32'd65536, 32'd65536, 32'd65536, 32'd16777);
        add_random(125);
        drain();

        // frozen smoothers, zero time step, sender gaps
        set_regs(32'd0, 32'd0, 32'd0, 32'd0);
        send_idle_pct = 56;
        add_random(125);
        drain();

        // weight above one, max step, receiver stalls with a long hold at the start
        set_regs(32'd131071, 32'd1, 32'd32768, 32'd1677721);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        add_random(125);
        hold_requests++;
        drain();

        // step above range, both sides idling
        set_regs($urandom_range(0, 131071), $urandom_range(0, 131071),
                 $urandom_range(0, 131071), 32'd2097151);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        add_random(125);
        drain();

        // random setting, sender gaps
        set_regs($urandom_range(0, 131071), $urandom_range(0, 131071),
                 $urandom_range(0, 131071), $urandom_range(1, 1677721));
        send_idle_pct = 56;
        recv_stall_pct = 0;
        add_random(125);
        drain();

        if (mismatch_count == 0)
            $display("imu_scale_filter_integrate_unit verification clean");
        else
            $display("imu_scale_filter_integrate_unit verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/isfi_pkg.sv
rtl/core/imu_scale_filter_integrate_unit.sv
tb/tb_imu_scale_filter_integrate_unit.sv
